### sv/svap_pkg.sv
// Shared types, constants and arithmetic helpers for the saturation and value adjust block.
package svap_pkg;

	typedef logic [7:0] pix_t;
	typedef logic [15:0] prod_t;
	typedef logic [2:0][7:0] pix_lanes_t;
	typedef logic [2:0][15:0] prod_lanes_t;

	localparam int unsigned LANES = 3;
	localparam int unsigned DIV_STAGES = 4;
	localparam int unsigned PIPE_STAGES = 13;

	localparam int unsigned VAL_FIRST = 0;
	localparam int unsigned SAT_FIRST = 1 + DIV_STAGES;
	localparam int unsigned SAT_STAGES = PIPE_STAGES - SAT_FIRST;

	localparam logic [8:0] SAT_ONE = 9'd256;
	localparam logic [7:0] TARGET_VALUE_RESET = 8'd255;
	localparam logic [8:0] SATURATION_RESET = 9'd256;

	localparam logic CFG_TARGET_VALUE = 1'b0;
	localparam logic CFG_SATURATION = 1'b1;

	typedef struct packed {
		pix_lanes_t ch;
		pix_t newlo;
		pix_t alpha;
	} sat_side_t;

	function automatic pix_t max3(input pix_t a, input pix_t b, input pix_t c);
		pix_t m;
		m = (a > b) ? a : b;
		return (m > c) ? m : c;
	endfunction

	function automatic pix_t min3(input pix_t a, input pix_t b, input pix_t c);
		pix_t m;
		m = (a < b) ? a : b;
		return (m < c) ? m : c;
	endfunction

	// One restoring division step: the top bit says whether the shifted divisor fitted.
	function automatic logic [16:0] div_step(input prod_t rem, input pix_t dvs,
			input logic [2:0] sh);
		prod_t shifted;
		shifted = prod_t'(dvs) << sh;
		if (rem >= shifted) begin
			return {1'b1, rem - shifted};
		end
		return {1'b0, rem};
	endfunction

endpackage

### sv/svap_in_if.sv
// Valid/ready channel that carries one input pixel.
interface svap_in_if;
	logic valid;
	logic ready;
	logic [7:0] red_in;
	logic [7:0] green_in;
	logic [7:0] blue_in;
	logic [7:0] alpha_in;

	modport source (output valid, output red_in, output green_in, output blue_in,
		output alpha_in, input ready);
	modport sink (input valid, input red_in, input green_in, input blue_in,
		input alpha_in, output ready);
endinterface

### sv/svap_out_if.sv
// Valid/ready channel that carries one adjusted pixel.
interface svap_out_if;
	logic valid;
	logic ready;
	logic [7:0] red_out;
	logic [7:0] green_out;
	logic [7:0] blue_out;
	logic [7:0] alpha_out;

	modport source (output valid, output red_out, output green_out, output blue_out,
		output alpha_out, input ready);
	modport sink (input valid, input red_out, input green_out, input blue_out,
		input alpha_out, output ready);
endinterface

### sv/svap_ctrl.sv
// Stage valid bits and per-stage advance enables for the pixel pipeline.
module svap_ctrl import svap_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	output logic [PIPE_STAGES-1:0] en
);

	logic [PIPE_STAGES-1:0] valid_q;

	// A stage may load when it is empty or when its contents move on.
	always_comb begin
		en[PIPE_STAGES-1] = !valid_q[PIPE_STAGES-1] || out_ready;
		for (int k = PIPE_STAGES - 2; k >= 0; k--) begin
			en[k] = !valid_q[k] || en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (en[0]) begin
				valid_q[0] <= in_valid;
			end
			for (int k = 1; k < PIPE_STAGES; k++) begin
				if (en[k]) begin
					valid_q[k] <= valid_q[k-1];
				end
			end
		end
	end

	assign in_ready = en[0];
	assign out_valid = valid_q[PIPE_STAGES-1];

endmodule

### sv/svap_div.sv
// Three-lane pipelined restoring divider with an 8-bit quotient, two bits per stage.
module svap_div import svap_pkg::*; (
	input  logic clk,
	input  logic [DIV_STAGES-1:0] en,
	input  prod_lanes_t num,
	input  pix_t dvs,
	output pix_lanes_t quo,
	output pix_t dvs_out
);

	prod_lanes_t rem_s [DIV_STAGES];
	pix_lanes_t quo_s [DIV_STAGES];
	pix_t dvs_s [DIV_STAGES];

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
		localparam logic [2:0] SH_HI = 3'(7 - 2 * k);
		localparam logic [2:0] SH_LO = 3'(6 - 2 * k);

		prod_lanes_t rem_in;
		pix_lanes_t quo_in;
		pix_t dvs_in;
		prod_lanes_t rem_nxt;
		pix_lanes_t quo_nxt;

		if (k == 0) begin : g_first
			assign rem_in = num;
			assign quo_in = '0;
			assign dvs_in = dvs;
		end else begin : g_rest
			assign rem_in = rem_s[k-1];
			assign quo_in = quo_s[k-1];
			assign dvs_in = dvs_s[k-1];
		end

		always_comb begin
			logic [16:0] st_hi;
			logic [16:0] st_lo;
			for (int i = 0; i < LANES; i++) begin
				st_hi = div_step(rem_in[i], dvs_in, SH_HI);
				st_lo = div_step(st_hi[15:0], dvs_in, SH_LO);
				rem_nxt[i] = st_lo[15:0];
				quo_nxt[i] = quo_in[i];
				quo_nxt[i][SH_HI] = st_hi[16];
				quo_nxt[i][SH_LO] = st_lo[16];
			end
		end

		always_ff @(posedge clk) begin
			if (en[k]) begin
				rem_s[k] <= rem_nxt;
				quo_s[k] <= quo_nxt;
				dvs_s[k] <= dvs_in;
			end
		end
	end

	assign quo = quo_s[DIV_STAGES-1];
	assign dvs_out = dvs_s[DIV_STAGES-1];

endmodule

### sv/svap_value.sv
// Value stage: scales each colour channel to the target level over the pixel maximum.
module svap_value import svap_pkg::*; (
	input  logic clk,
	input  logic [DIV_STAGES:0] en,
	input  pix_lanes_t ch_in,
	input  pix_t alpha_in,
	input  pix_t target_value,
	output pix_lanes_t ch_out,
	output pix_t alpha_out
);

	prod_lanes_t prod_s1;
	pix_t cur_s1;
	pix_t alpha_s1;
	pix_t alpha_s [DIV_STAGES];
	pix_lanes_t quo;
	pix_t cur_out;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int i = 0; i < LANES; i++) begin
				prod_s1[i] <= prod_t'(ch_in[i]) * prod_t'(target_value);
			end
			cur_s1 <= max3(ch_in[0], ch_in[1], ch_in[2]);
			alpha_s1 <= alpha_in;
		end
	end

	svap_div u_div (
		.clk     (clk),
		.en      (en[DIV_STAGES:1]),
		.num     (prod_s1),
		.dvs     (cur_s1),
		.quo     (quo),
		.dvs_out (cur_out)
	);

	always_ff @(posedge clk) begin
		if (en[1]) begin
			alpha_s[0] <= alpha_s1;
		end
		for (int k = 1; k < DIV_STAGES; k++) begin
			if (en[k+1]) begin
				alpha_s[k] <= alpha_s[k-1];
			end
		end
	end

	// A black pixel keeps its zero channels.
	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			ch_out[i] = (cur_out == '0) ? '0 : quo[i];
		end
	end

	assign alpha_out = alpha_s[DIV_STAGES-1];

endmodule

### sv/svap_sat.sv
// Saturation stage: remaps the channels from their own range onto the raised floor.
module svap_sat import svap_pkg::*; (
	input  logic clk,
	input  logic [SAT_STAGES-1:0] en,
	input  pix_lanes_t ch_in,
	input  pix_t alpha_in,
	input  logic [8:0] saturation_level,
	output pix_lanes_t ch_out,
	output pix_t alpha_out
);

	pix_lanes_t ch_s6;
	pix_t hi_s6;
	pix_t lo_s6;
	pix_t alpha_s6;

	pix_lanes_t ch_s7;
	pix_lanes_t diff_s7;
	pix_t hi_s7;
	pix_t newlo_s7;
	pix_t den_s7;
	pix_t alpha_s7;

	prod_lanes_t prod_s8;
	pix_t den_s8;
	sat_side_t side_s8;

	sat_side_t side_s [DIV_STAGES];
	pix_lanes_t ch_s13;
	pix_t alpha_s13;

	pix_lanes_t quo;
	pix_t den_out;
	logic [8:0] sat_eff;
	logic [16:0] floor_prod;
	pix_t range;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			ch_s6 <= ch_in;
			hi_s6 <= max3(ch_in[0], ch_in[1], ch_in[2]);
			lo_s6 <= min3(ch_in[0], ch_in[1], ch_in[2]);
			alpha_s6 <= alpha_in;
		end
	end

	assign sat_eff = (saturation_level > SAT_ONE) ? SAT_ONE : saturation_level;
	assign floor_prod = 17'(hi_s6) * 17'(SAT_ONE - sat_eff);

	always_ff @(posedge clk) begin
		if (en[1]) begin
			ch_s7 <= ch_s6;
			for (int i = 0; i < LANES; i++) begin
				diff_s7[i] <= ch_s6[i] - lo_s6;
			end
			hi_s7 <= hi_s6;
			newlo_s7 <= floor_prod[15:8];
			den_s7 <= hi_s6 - lo_s6;
			alpha_s7 <= alpha_s6;
		end
	end

	assign range = hi_s7 - newlo_s7;

	always_ff @(posedge clk) begin
		if (en[2]) begin
			for (int i = 0; i < LANES; i++) begin
				prod_s8[i] <= prod_t'(diff_s7[i]) * prod_t'(range);
			end
			den_s8 <= den_s7;
			side_s8.ch <= ch_s7;
			side_s8.newlo <= newlo_s7;
			side_s8.alpha <= alpha_s7;
		end
	end

	svap_div u_div (
		.clk     (clk),
		.en      (en[DIV_STAGES+2:3]),
		.num     (prod_s8),
		.dvs     (den_s8),
		.quo     (quo),
		.dvs_out (den_out)
	);

	always_ff @(posedge clk) begin
		if (en[3]) begin
			side_s[0] <= side_s8;
		end
		for (int k = 1; k < DIV_STAGES; k++) begin
			if (en[k+3]) begin
				side_s[k] <= side_s[k-1];
			end
		end
	end

	// A grey pixel leaves the remap untouched.
	always_ff @(posedge clk) begin
		if (en[SAT_STAGES-1]) begin
			for (int i = 0; i < LANES; i++) begin
				ch_s13[i] <= (den_out == '0) ? side_s[DIV_STAGES-1].ch[i]
					: quo[i] + side_s[DIV_STAGES-1].newlo;
			end
			alpha_s13 <= side_s[DIV_STAGES-1].alpha;
		end
	end

	assign ch_out = ch_s13;
	assign alpha_out = alpha_s13;

endmodule

### sv/pixel_saturation_value_adjust_core.sv
// Top level of the pixel saturation and value adjust block.
//
// Pixels arrive as requests on pix_in and leave on pix_out, both valid/ready
// channels that move one RGBA8 pixel per request. Each colour channel is first
// scaled so that the largest reaches target_value, then the channels are
// remapped onto a floor set by saturation_level. Alpha passes through.
// The two settings are written through cfg_we, cfg_index and cfg_data; index 0 is
// target_value and index 1 is saturation_level. The user must write them only
// while no pixel is in flight; the block itself does not enforce this.
// The pipeline has 13 register stages, and one pixel can be accepted every cycle
// while in_ready is high. The depth is set by the two dividers, each of which
// resolves two quotient bits per stage over four stages.
// Every stage holds its own valid bit, so when the receiver stalls the result
// waits in the output register while empty stages further back still fill.
// Reset empties the pipeline and restores target_value to 255 and
// saturation_level to 256.
module pixel_saturation_value_adjust_core import svap_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	svap_in_if.sink pix_in,
	svap_out_if.source pix_out,
	input  logic cfg_we,
	input  logic cfg_index,
	input  logic [8:0] cfg_data
);

	pix_t target_value_q;
	logic [8:0] saturation_q;
	logic [PIPE_STAGES-1:0] en;
	pix_lanes_t ch_in;
	pix_lanes_t ch_val;
	pix_t alpha_val;
	pix_lanes_t ch_res;
	pix_t alpha_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_value_q <= TARGET_VALUE_RESET;
			saturation_q <= SATURATION_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_TARGET_VALUE: target_value_q <= cfg_data[7:0];
				CFG_SATURATION: saturation_q <= cfg_data;
				default: ;
			endcase
		end
	end

	svap_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pix_in.valid),
		.in_ready  (pix_in.ready),
		.out_valid (pix_out.valid),
		.out_ready (pix_out.ready),
		.en        (en)
	);

	assign ch_in[0] = pix_in.red_in;
	assign ch_in[1] = pix_in.green_in;
	assign ch_in[2] = pix_in.blue_in;

	svap_value u_value (
		.clk          (clk),
		.en           (en[SAT_FIRST-1:VAL_FIRST]),
		.ch_in        (ch_in),
		.alpha_in     (pix_in.alpha_in),
		.target_value (target_value_q),
		.ch_out       (ch_val),
		.alpha_out    (alpha_val)
	);

	svap_sat u_sat (
		.clk              (clk),
		.en               (en[PIPE_STAGES-1:SAT_FIRST]),
		.ch_in            (ch_val),
		.alpha_in         (alpha_val),
		.saturation_level (saturation_q),
		.ch_out           (ch_res),
		.alpha_out        (alpha_res)
	);

	assign pix_out.red_out = ch_res[0];
	assign pix_out.green_out = ch_res[1];
	assign pix_out.blue_out = ch_res[2];
	assign pix_out.alpha_out = alpha_res;

endmodule

### test/tb.sv
// Self-checking testbench for the pixel saturation and value adjust block.
`timescale 1ns / 1ps

module tb;
	import svap_pkg::*;

	typedef struct packed {
		pix_t red;
		pix_t green;
		pix_t blue;
		pix_t alpha;
	} rgba_t;

	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 54;
	localparam int LONG_STALL = 150;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_index;
	logic [8:0] cfg_data;

	svap_in_if pix_in_ch ();
	svap_out_if pix_out_ch ();

	pixel_saturation_value_adjust_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.pix_in(pix_in_ch),
		.pix_out(pix_out_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	rgba_t pending_pixels[$];
	rgba_t adjusted_pixels[$];
	int unsigned accepted_cnt = 0;
	int unsigned returned_cnt = 0;
	int errors = 0;
	logic [7:0] tgt_level = TARGET_VALUE_RESET;
	logic [8:0] sat_level = SATURATION_RESET;
	logic steady = 1'b0;
	int stall_reqs = 0;
	int stalls_done;
	int stall_left;

	logic [7:0] tgt_list [0:PHASES-1] = '{8'd0, 8'd255, 8'd1, 8'd128, 8'd200, 8'd37, 8'd255,
		8'd90};
	logic [8:0] sat_list [0:PHASES-1] = '{9'd0, 9'd0, 9'd256, 9'd128, 9'd511, 9'd300, 9'd257,
		9'd1};

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Value scaling to the target level, then the remap of the channels onto the new floor.
	function automatic rgba_t adjust_pixel(input rgba_t px, input logic [7:0] tgt,
			input logic [8:0] sat_cfg);
		int unsigned c [3];
		int unsigned top, hi, lo, sat, new_floor;
		rgba_t res;
		c[0] = px.red;
		c[1] = px.green;
		c[2] = px.blue;
		top = 0;
		for (int i = 0; i < 3; i++) begin
			if (c[i] > top) begin
				top = c[i];
			end
		end
		if (top != 0) begin
			for (int i = 0; i < 3; i++) begin
				c[i] = (c[i] * tgt) / top;
			end
		end
		hi = c[0];
		lo = c[0];
		for (int i = 1; i < 3; i++) begin
			if (c[i] > hi) begin
				hi = c[i];
			end
			if (c[i] < lo) begin
				lo = c[i];
			end
		end
		if (hi != lo) begin
			sat = (sat_cfg > SAT_ONE) ? SAT_ONE : sat_cfg;
			new_floor = (hi * (SAT_ONE - sat)) >> 8;
			for (int i = 0; i < 3; i++) begin
				c[i] = ((c[i] - lo) * (hi - new_floor)) / (hi - lo) + new_floor;
			end
		end
		res.red = pix_t'(c[0]);
		res.green = pix_t'(c[1]);
		res.blue = pix_t'(c[2]);
		res.alpha = px.alpha;
		return res;
	endfunction

	function automatic rgba_t random_pixel();
		int unsigned kind;
		rgba_t px;
		kind = $urandom_range(99);
		px.alpha = pix_t'($urandom_range(255));
		if (kind < 60) begin
			px.red = pix_t'($urandom_range(255));
			px.green = pix_t'($urandom_range(255));
			px.blue = pix_t'($urandom_range(255));
		end else if (kind < 75) begin
			px.red = pix_t'($urandom_range(7));
			px.green = pix_t'($urandom_range(7));
			px.blue = pix_t'($urandom_range(7));
		end else if (kind < 85) begin
			px.red = pix_t'($urandom_range(255));
			px.green = px.red;
			px.blue = px.red;
		end else if (kind < 90) begin
			px.red = '0;
			px.green = '0;
			px.blue = '0;
		end else begin
			px.red = pix_t'($urandom_range(255));
			px.green = px.red;
			px.blue = pix_t'($urandom_range(255));
		end
		return px;
	endfunction

	always @(posedge clk) begin : driver
		rgba_t nxt;
		if (!arst_n) begin
			pix_in_ch.valid <= 1'b0;
		end else begin
			if (pix_in_ch.valid && pix_in_ch.ready) begin
				adjusted_pixels.push_back(adjust_pixel({pix_in_ch.red_in, pix_in_ch.green_in,
					pix_in_ch.blue_in, pix_in_ch.alpha_in}, tgt_level, sat_level));
				accepted_cnt <= accepted_cnt + 1;
			end
			if (!pix_in_ch.valid || pix_in_ch.ready) begin
				if (pending_pixels.size() != 0 && (steady || $urandom_range(99) >= 15)) begin
					nxt = pending_pixels.pop_front();
					pix_in_ch.red_in <= nxt.red;
					pix_in_ch.green_in <= nxt.green;
					pix_in_ch.blue_in <= nxt.blue;
					pix_in_ch.alpha_in <= nxt.alpha;
					pix_in_ch.valid <= 1'b1;
				end else begin
					pix_in_ch.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : monitor
		rgba_t want;
		if (!arst_n) begin
			pix_out_ch.ready <= 1'b0;
			stall_left <= 0;
			stalls_done <= 0;
		end else begin
			if (pix_out_ch.valid && pix_out_ch.ready) begin
				if (returned_cnt == accepted_cnt) begin
					$error("result with no request waiting");
					errors++;
				end else begin
					want = adjusted_pixels.pop_front();
					returned_cnt <= returned_cnt + 1;
					if (pix_out_ch.red_out !== want.red) begin
						$error("red_out: expected %0d, got %0d", want.red, pix_out_ch.red_out);
						errors++;
					end
					if (pix_out_ch.green_out !== want.green) begin
						$error("green_out: expected %0d, got %0d", want.green,
							pix_out_ch.green_out);
						errors++;
					end
					if (pix_out_ch.blue_out !== want.blue) begin
						$error("blue_out: expected %0d, got %0d", want.blue, pix_out_ch.blue_out);
						errors++;
					end
					if (pix_out_ch.alpha_out !== want.alpha) begin
						$error("alpha_out: expected %0d, got %0d", want.alpha,
							pix_out_ch.alpha_out);
						errors++;
					end
				end
			end
			if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				pix_out_ch.ready <= 1'b0;
			end else if (stalls_done != stall_reqs) begin
				stalls_done <= stalls_done + 1;
				stall_left <= LONG_STALL;
				pix_out_ch.ready <= 1'b0;
			end else begin
				pix_out_ch.ready <= steady || ($urandom_range(99) >= 15);
			end
		end
	end

	task automatic write_reg(input logic idx, input logic [8:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		if (idx == CFG_TARGET_VALUE) begin
			tgt_level = val[7:0];
		end else begin
			sat_level = val;
		end
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_drained();
		do begin
			@(negedge clk);
		end while (pending_pixels.size() != 0 || pix_in_ch.valid || accepted_cnt != returned_cnt);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_TARGET_VALUE;
		cfg_data = '0;
		pix_in_ch.valid = 1'b0;
		pix_in_ch.red_in = '0;
		pix_in_ch.green_in = '0;
		pix_in_ch.blue_in = '0;
		pix_in_ch.alpha_in = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Black, grey and pure primaries first, then ties, tiny maxima and awkward ratios.
		pending_pixels.push_back('{8'd0, 8'd0, 8'd0, 8'd0});
		pending_pixels.push_back('{8'd0, 8'd0, 8'd0, 8'd255});
		pending_pixels.push_back('{8'd255, 8'd255, 8'd255, 8'd128});
		pending_pixels.push_back('{8'd128, 8'd128, 8'd128, 8'd1});
		pending_pixels.push_back('{8'd1, 8'd1, 8'd1, 8'd254});
		pending_pixels.push_back('{8'd255, 8'd0, 8'd0, 8'd255});
		pending_pixels.push_back('{8'd0, 8'd255, 8'd0, 8'd0});
		pending_pixels.push_back('{8'd0, 8'd0, 8'd255, 8'd85});
		pending_pixels.push_back('{8'd1, 8'd0, 8'd0, 8'd170});
		pending_pixels.push_back('{8'd0, 8'd0, 8'd1, 8'd15});
		pending_pixels.push_back('{8'd255, 8'd254, 8'd0, 8'd240});
		pending_pixels.push_back('{8'd1, 8'd2, 8'd3, 8'd7});
		pending_pixels.push_back('{8'd254, 8'd1, 8'd128, 8'd64});
		pending_pixels.push_back('{8'd100, 8'd50, 8'd25, 8'd200});
		pending_pixels.push_back('{8'd3, 8'd0, 8'd255, 8'd3});
		pending_pixels.push_back('{8'd7, 8'd7, 8'd0, 8'd100});
		pending_pixels.push_back('{8'd200, 8'd200, 8'd199, 8'd33});
		pending_pixels.push_back('{8'd85, 8'd170, 8'd255, 8'd170});
		wait_drained();

		for (int p = 0; p < PHASES; p++) begin
			if (p == PHASES - 1) begin
				write_reg(CFG_TARGET_VALUE, 9'($urandom_range(255)));
				write_reg(CFG_SATURATION, 9'($urandom_range(511)));
			end else begin
				write_reg(CFG_TARGET_VALUE, {1'b0, tgt_list[p]});
				write_reg(CFG_SATURATION, sat_list[p]);
			end
			@(negedge clk);
			steady = (p == 2);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				pending_pixels.push_back(random_pixel());
				if (p == 4 && n == PHASE_ITEMS / 2) begin
					wait_drained();
				end
			end
			if (p == 3) begin
				stall_reqs = stall_reqs + 1;
			end
			wait_drained();
		end
		steady = 1'b0;

		repeat (20) @(negedge clk);
		if (errors == 0 && adjusted_pixels.size() == 0) begin
			$display("pixel_saturation_value_adjust_core test passed");
		end else begin
			$display("pixel_saturation_value_adjust_core test failed");
		end
		$finish;
	end

	initial begin
		#3000000;
		$display("pixel_saturation_value_adjust_core test failed");
		$finish;
	end

endmodule

### pixel_saturation_value_adjust_core.f
sv/svap_pkg.sv
sv/svap_in_if.sv
sv/svap_out_if.sv
sv/svap_ctrl.sv
sv/svap_div.sv
sv/svap_value.sv
sv/svap_sat.sv
sv/pixel_saturation_value_adjust_core.sv
test/tb.sv
